// ----- design/qws_pkg.sv -----
// ----------------------------------------------------------------------------
// qws_pkg - shared types and helpers of the quoted word splitter
// Scan modes, result item layout and the byte-level helper functions.
// ----------------------------------------------------------------------------
package qws_pkg;

	localparam int QWS_FIFO_DEPTH = 4;

	localparam logic [7:0] CHR_QUOTE = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5C;

	typedef enum logic [4:0] {
		MODE_GAP   = 5'b00001,
		MODE_WORD  = 5'b00010,
		MODE_QUOTE = 5'b00100,
		MODE_ESC   = 5'b01000,
		MODE_OCTAL = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       word_last;
	} res_t;

	// results of one item, pushed into the output queue together
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	// held byte plus results gathered so far while one item is worked on
	typedef struct packed {
		logic [7:0] held_byte;
		logic       held_valid;
		push_t      push;
	} acc_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
			(b == 8'h0B) || (b == 8'h0C);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic [7:0] escape_code(input logic [7:0] b);
		logic [7:0] v;
		unique case (b)
			8'h61: v = 8'h07;  // a
			8'h62: v = 8'h08;  // b
			8'h66: v = 8'h0C;  // f
			8'h6E: v = 8'h0A;  // n
			8'h72: v = 8'h0D;  // r
			8'h74: v = 8'h09;  // t
			8'h76: v = 8'h0B;  // v
			default: v = b;
		endcase
		return v;
	endfunction

	function automatic acc_t put_res(input acc_t a, input res_t r);
		acc_t o;
		o = a;
		if (a.push.n == 2'd0) begin
			o.push.r0 = r;
			o.push.n = 2'd1;
		end else begin
			o.push.r1 = r;
			o.push.n = 2'd2;
		end
		return o;
	endfunction

	// the previous byte goes out, the new one is held back
	function automatic acc_t add_byte(input acc_t a, input logic [7:0] b);
		acc_t o;
		res_t r;
		o = a;
		r.out_byte = a.held_byte;
		r.has_byte = 1'b1;
		r.word_last = 1'b0;
		if (a.held_valid) begin
			o = put_res(a, r);
		end
		o.held_byte = b;
		o.held_valid = 1'b1;
		return o;
	endfunction

	function automatic acc_t end_word(input acc_t a);
		acc_t o;
		res_t r;
		r.out_byte = a.held_valid ? a.held_byte : 8'h00;
		r.has_byte = a.held_valid;
		r.word_last = 1'b1;
		o = put_res(a, r);
		o.held_byte = 8'h00;
		o.held_valid = 1'b0;
		return o;
	endfunction

endpackage

// ----- design/qws_core.sv -----
// ----------------------------------------------------------------------------
// qws_core - scan state and result generation
// Updates the scan state for one item and gives the zero to two results.
// ----------------------------------------------------------------------------
module qws_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic          op,
	input  logic [7:0]    in_byte,
	output qws_pkg::push_t push
);
	import qws_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [7:0] octal_value_q, octal_value_d;
	logic [1:0] octal_digits_q, octal_digits_d;
	acc_t       acc_d;

	always_comb begin
		mode_t      m;
		acc_t       a;
		logic [7:0] ov;
		logic [1:0] od;
		logic       done;
		logic [7:0] ev;

		unique case (mode_q)
			MODE_GAP, MODE_WORD, MODE_QUOTE, MODE_ESC, MODE_OCTAL: m = mode_q;
			default: m = MODE_GAP;
		endcase
		a.held_byte = held_byte_q;
		a.held_valid = held_valid_q;
		a.push = '0;
		ov = octal_value_q;
		od = octal_digits_q;
		done = 1'b0;
		ev = escape_code(in_byte);

		if (op) begin
			if (m == MODE_OCTAL) begin
				if (ov != 8'h00) a = add_byte(a, ov);
				ov = 8'h00;
				od = 2'd0;
				m = MODE_QUOTE;
			end
			if (m != MODE_GAP) begin
				a = end_word(a);
				m = MODE_GAP;
			end
			done = 1'b1;
		end else if (m == MODE_OCTAL) begin
			if (is_digit(in_byte) && od != 2'd3) begin
				ov = {ov[4:0], 3'b000} + {4'h0, in_byte[3:0]};
				od = od + 2'd1;
				done = 1'b1;
				// third digit closes the escape
				if (od == 2'd3) begin
					if (ov != 8'h00) a = add_byte(a, ov);
					ov = 8'h00;
					od = 2'd0;
					m = MODE_QUOTE;
				end
			end else begin
				if (ov != 8'h00) a = add_byte(a, ov);
				ov = 8'h00;
				od = 2'd0;
				m = MODE_QUOTE;
			end
		end

		if (!done && m == MODE_GAP) begin
			if (is_space(in_byte)) done = 1'b1;
			else m = MODE_WORD;
		end

		if (!done) begin
			unique case (m)
				MODE_WORD: begin
					if (is_space(in_byte)) begin
						a = end_word(a);
						m = MODE_GAP;
					end else if (in_byte == CHR_QUOTE) begin
						m = MODE_QUOTE;
					end else begin
						a = add_byte(a, in_byte);
					end
				end
				MODE_QUOTE: begin
					if (in_byte == CHR_QUOTE) m = MODE_WORD;
					else if (in_byte == CHR_BSLASH) m = MODE_ESC;
					else a = add_byte(a, in_byte);
				end
				MODE_ESC: begin
					if (is_digit(in_byte)) begin
						ov = {4'h0, in_byte[3:0]};
						od = 2'd1;
						m = MODE_OCTAL;
					end else begin
						if (ev != 8'h00) a = add_byte(a, ev);
						m = MODE_QUOTE;
					end
				end
				default: begin
				end
			endcase
		end

		mode_d = m;
		acc_d = a;
		octal_value_d = ov;
		octal_digits_d = od;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GAP;
			held_byte_q <= 8'h00;
			held_valid_q <= 1'b0;
			octal_value_q <= 8'h00;
			octal_digits_q <= 2'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			held_byte_q <= acc_d.held_byte;
			held_valid_q <= acc_d.held_valid;
			octal_value_q <= octal_value_d;
			octal_digits_q <= octal_digits_d;
		end
	end

	assign push = acc_d.push;

	// two results are always a plain byte first
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && push.n == 2'd2 |-> push.r0.has_byte && !push.r0.word_last)
		else $error("qws_core: first of two results is not a plain byte");

	// a byte is only held back inside a word
	assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> mode_q != MODE_GAP)
		else $error("qws_core: held byte left between words");

endmodule

// ----- design/qws_fifo.sv -----
// ----------------------------------------------------------------------------
// qws_fifo - output queue of result items
// Takes up to two results per cycle, hands out one per handshake.
// ----------------------------------------------------------------------------
module qws_fifo #(
	parameter int DEPTH = qws_pkg::QWS_FIFO_DEPTH  // power of two, at least 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_en,
	input  qws_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output qws_pkg::res_t  head
);
	import qws_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       push_n;
	logic             pop;

	assign push_n = push_en ? push.n : 2'd0;
	assign pop = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];
	// room for the worst case of two results
	assign room = count_q <= CNT_W'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push_n == 2'd2) mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("qws_fifo: count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("qws_fifo: count not lowered after a pop");

endmodule

// ----- design/quoted_word_splitter_top.sv -----
// ----------------------------------------------------------------------------
// quoted_word_splitter_top - shell-style word splitter with C escapes
// Splits a byte stream into words and emits the word bytes.
// ----------------------------------------------------------------------------
// Input channel s_axis: one text byte per item in tdata; tuser is the item
// kind, 0 for a text byte and 1 for end of text, which closes an open word.
// Output channel m_axis: one word byte per item in tdata, tuser high when
// the item carries a byte (low only for the single item of an empty word),
// tlast high on the item that ends a word.
// Each input item is taken into an input register and worked on there; its
// results are written into a small output queue, from which m_axis is
// driven. The core only works on an item while the queue has room.
// An input item gives zero, one or two results. Input items are taken in
// every cycle while the queue holds at most DEPTH-2 results; the sustained
// rate is then set by the output side at one result per cycle.
// When the receiver stalls, the queue fills and s_axis_tready falls; nothing
// is lost. Reset clears the scan state (between words, nothing held) and
// empties the queue.
// ----------------------------------------------------------------------------
module quoted_word_splitter_top #(
	parameter int FIFO_DEPTH = qws_pkg::QWS_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tuser,   // [0] op
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] has_byte
	output logic       m_axis_tlast
);
	import qws_pkg::*;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       room;
	logic       fire;
	push_t      push;
	res_t       head;

	assign fire = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	qws_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.op      (op_s1),
		.in_byte (byte_s1),
		.push    (push)
	);

	qws_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (fire),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.head      (head)
	);

	assign m_axis_tdata = head.out_byte;
	assign m_axis_tuser = head.has_byte;
	assign m_axis_tlast = head.word_last;

endmodule

// ----- tb/sv/tb_quoted_word_splitter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_word_splitter_top - self-checking bench of the word splitter
// A short directed table (empty words, raw zero bytes, escapes, octal digits,
// flushes of open quotes) is followed by random text rich in quotes,
// backslashes and digits. Word bytes leaving m_axis are compared in order
// against a behavioral tokenizer or, where a table row gives them, its own results.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_quoted_word_splitter_top;

	localparam int RANDOM_ITEMS = 1820;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic          op;
		logic [7:0]    b;
		int            n;   // negative: results come from the tokenizer
		qws_pkg::res_t r0;
		qws_pkg::res_t r1;
	} stim_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	// tokenizer state
	qws_pkg::mode_t tk_mode;
	logic           tk_open;
	logic [7:0]     tk_held;
	logic           tk_held_ok;
	logic [7:0]     tk_oct_val;
	logic [1:0]     tk_oct_cnt;

	qws_pkg::res_t step_buf[$];
	qws_pkg::res_t expected_words[$];
	stim_t         stim_q[$];
	stim_t         cur;

	int   err_count;
	int   cycles;
	int   rx_tick;
	logic [7:0] rx_pattern;

	quoted_word_splitter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic bit blank_char(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0B ||
			b == 8'h0C;
	endfunction

	function automatic bit numeral(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic [7:0] ctrl_code(input logic [7:0] b);
		case (b)
			"a": return 8'h07;
			"b": return 8'h08;
			"f": return 8'h0C;
			"n": return 8'h0A;
			"r": return 8'h0D;
			"t": return 8'h09;
			"v": return 8'h0B;
			default: return b;
		endcase
	endfunction

	task automatic emit_word_byte(input logic [7:0] b, input logic has, input logic last);
		qws_pkg::res_t r;
		r.out_byte = b;
		r.has_byte = has;
		r.word_last = last;
		if (step_buf.size() < 2)
			step_buf.push_back(r);
	endtask

	// one byte is always held back so the last one can carry word_last
	task automatic hold_byte(input logic [7:0] b);
		if (tk_held_ok)
			emit_word_byte(tk_held, 1'b1, 1'b0);
		tk_held = b;
		tk_held_ok = 1'b1;
	endtask

	task automatic close_word();
		emit_word_byte(tk_held_ok ? tk_held : 8'h00, tk_held_ok, 1'b1);
		tk_held = 8'h00;
		tk_held_ok = 1'b0;
		tk_open = 1'b0;
		tk_mode = qws_pkg::MODE_GAP;
	endtask

	task automatic close_octal();
		if (tk_oct_val != 8'h00)
			hold_byte(tk_oct_val);
		tk_oct_val = 8'h00;
		tk_oct_cnt = 2'd0;
		tk_mode = qws_pkg::MODE_QUOTE;
	endtask

	task automatic tokenize(input logic op, input logic [7:0] b);
		step_buf.delete();
		if (op) begin
			if (tk_mode == qws_pkg::MODE_OCTAL)
				close_octal();
			if (tk_mode != qws_pkg::MODE_GAP)
				close_word();
			return;
		end
		if (tk_mode == qws_pkg::MODE_OCTAL) begin
			if (numeral(b) && tk_oct_cnt < 2'd3) begin
				tk_oct_val = {tk_oct_val[4:0], 3'b000} + (b - 8'h30);
				tk_oct_cnt = tk_oct_cnt + 2'd1;
				if (tk_oct_cnt == 2'd3)
					close_octal();
				return;
			end
			close_octal();
		end
		if (tk_mode == qws_pkg::MODE_GAP) begin
			if (blank_char(b))
				return;
			tk_open = 1'b1;
			tk_mode = qws_pkg::MODE_WORD;
		end
		case (tk_mode)
			qws_pkg::MODE_WORD: begin
				if (blank_char(b))
					close_word();
				else if (b == qws_pkg::CHR_QUOTE)
					tk_mode = qws_pkg::MODE_QUOTE;
				else
					hold_byte(b);
			end
			qws_pkg::MODE_QUOTE: begin
				if (b == qws_pkg::CHR_QUOTE)
					tk_mode = qws_pkg::MODE_WORD;
				else if (b == qws_pkg::CHR_BSLASH)
					tk_mode = qws_pkg::MODE_ESC;
				else
					hold_byte(b);
			end
			qws_pkg::MODE_ESC: begin
				if (numeral(b)) begin
					tk_oct_val = b - 8'h30;
					tk_oct_cnt = 2'd1;
					tk_mode = qws_pkg::MODE_OCTAL;
				end else begin
					if (ctrl_code(b) != 8'h00)
						hold_byte(ctrl_code(b));
					tk_mode = qws_pkg::MODE_QUOTE;
				end
			end
			default: ;
		endcase
	endtask

	function automatic stim_t stim_row(input logic op, input logic [7:0] b, input int n,
		input qws_pkg::res_t r0, input qws_pkg::res_t r1);
		stim_t s;
		s.op = op;
		s.b = b;
		s.n = n;
		s.r0 = r0;
		s.r1 = r1;
		return s;
	endfunction

	// random text weighted toward quotes, escapes and digits
	function automatic stim_t random_row();
		stim_t s;
		int pick;
		logic [7:0] blanks[6];
		logic [7:0] escs[7];
		blanks = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
		escs = '{"a", "b", "f", "n", "r", "t", "v"};
		pick = $urandom_range(0, 99);
		s.op = 1'b0;
		s.n = -1;
		s.r0 = '0;
		s.r1 = '0;
		s.b = 8'($urandom_range(0, 255));
		if (pick < 3)
			s.op = 1'b1;
		else if (pick < 16)
			s.b = blanks[$urandom_range(0, 5)];
		else if (pick < 28)
			s.b = qws_pkg::CHR_QUOTE;
		else if (pick < 38)
			s.b = qws_pkg::CHR_BSLASH;
		else if (pick < 53)
			s.b = 8'h30 + 8'($urandom_range(0, 9));
		else if (pick < 62)
			s.b = escs[$urandom_range(0, 6)];
		else if (pick < 82)
			s.b = 8'("a") + 8'($urandom_range(0, 25));
		else if (pick < 88)
			s.b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return s;
	endfunction

	task automatic note_mismatch(input qws_pkg::res_t got, input qws_pkg::res_t want,
		input bit orphan);
		if (err_count < MAX_SHOWN) begin
			if (orphan)
				$display("unexpected result: byte %02h has %0d last %0d",
					got.out_byte, got.has_byte, got.word_last);
			else
				$display("mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
					want.out_byte, want.has_byte, want.word_last,
					got.out_byte, got.has_byte, got.word_last);
		end
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		qws_pkg::res_t got;
		qws_pkg::res_t want;
		if (!arst_n) begin
			tk_mode = qws_pkg::MODE_GAP;
			tk_open = 1'b0;
			tk_held = 8'h00;
			tk_held_ok = 1'b0;
			tk_oct_val = 8'h00;
			tk_oct_cnt = 2'd0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
				if (expected_words.size() == 0) begin
					note_mismatch(got, got, 1'b1);
				end else begin
					want = expected_words.pop_front();
					if (got !== want)
						note_mismatch(got, want, 1'b0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				tokenize(s_axis_tuser, s_axis_tdata);
				if (cur.n < 0) begin
					foreach (step_buf[k])
						expected_words.push_back(step_buf[k]);
				end else begin
					if (cur.n > 0)
						expected_words.push_back(cur.r0);
					if (cur.n > 1)
						expected_words.push_back(cur.r1);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stalls on a repeating random pattern; every fifth draw of it never stalls
	always @(negedge clk) begin
		if (rx_tick % 64 == 0) begin
			if ((rx_tick / 64) % 5 == 4)
				rx_pattern = 8'hFF;
			else
				rx_pattern = 8'($urandom_range(0, 255)) | 8'h01;
		end
		m_axis_tready <= rx_pattern[rx_tick % 8];
		rx_tick++;
	end

	initial begin : driver
		qws_pkg::res_t none;
		int burst_left;
		int gap;
		none = '0;
		burst_left = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tuser = 1'b0;

		// flush between words, blanks, empty quotes, extremes, raw zero byte
		stim_q.push_back(stim_row(1'b1, 8'h00, 0, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h20, 0, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h22, 0, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h22, 0, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h09, 1, {8'h00, 1'b0, 1'b1}, none));
		stim_q.push_back(stim_row(1'b0, 8'hFF, 0, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h00, 1, {8'hFF, 1'b1, 1'b0}, none));
		stim_q.push_back(stim_row(1'b0, 8'h0A, 1, {8'h00, 1'b1, 1'b1}, none));
		// literal blank in quotes, backslash zero, three-digit escape with 9s
		stim_q.push_back(stim_row(1'b0, 8'h22, -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h20, -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h5C, -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h00, -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h5C, -1, none, none));
		stim_q.push_back(stim_row(1'b0, "9", -1, none, none));
		stim_q.push_back(stim_row(1'b0, "9", -1, none, none));
		stim_q.push_back(stim_row(1'b0, "7", -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h22, -1, none, none));
		// backslash outside quotes is an ordinary byte
		stim_q.push_back(stim_row(1'b0, 8'h5C, -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h0D, -1, none, none));
		// octal escape that wraps to zero
		stim_q.push_back(stim_row(1'b0, 8'h22, -1, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h5C, -1, none, none));
		stim_q.push_back(stim_row(1'b0, "4", -1, none, none));
		stim_q.push_back(stim_row(1'b0, "0", -1, none, none));
		stim_q.push_back(stim_row(1'b0, "0", -1, none, none));
		// pending octal escape and open quote closed by flush
		stim_q.push_back(stim_row(1'b0, 8'h5C, -1, none, none));
		stim_q.push_back(stim_row(1'b0, "7", -1, none, none));
		stim_q.push_back(stim_row(1'b1, 8'hFF, -1, none, none));
		// lone trailing backslash leaves an empty word
		stim_q.push_back(stim_row(1'b0, 8'h22, 0, none, none));
		stim_q.push_back(stim_row(1'b0, 8'h5C, 0, none, none));
		stim_q.push_back(stim_row(1'b1, 8'h00, 1, {8'h00, 1'b0, 1'b1}, none));

		repeat (RANDOM_ITEMS)
			stim_q.push_back(random_row());
		// close whatever the random text left open
		stim_q.push_back(stim_row(1'b1, 8'h00, -1, none, none));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_q[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ((i / 256) % 4 == 3) ? 0 : $urandom_range(0, 5);
			end else begin
				gap = 0;
			end
			burst_left--;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			cur = stim_q[i];
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= cur.b;
			s_axis_tuser <= cur.op;
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (err_count == 0 && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
